### design/erlo_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package erlo_pkg;

	// Default number of entries held in the ring.
	localparam int RING_DEPTH_DEF = 64;

	// Widths of the fields.
	localparam int TS_W    = 64;
	localparam int SEQ_W   = 32;
	localparam int CODE_W  = 8;
	localparam int SEV_W   = 3;
	localparam int DET_W   = 32;
	localparam int IDX_W   = 6;
	localparam int CNT_O_W = 7;
	localparam int DROP_W  = 32;

	// Packed stream word widths, rounded up to whole bytes.
	localparam int IN_DATA_W  = 120;
	localparam int OUT_DATA_W = 192;

	// The first sequence number handed out, and the one used after a wrap.
	localparam logic [SEQ_W-1:0] SEQ_FIRST = 32'd1;

	// Operation codes carried in the slave-side tuser.
	typedef enum logic {
		OP_PUSH = 1'b0,
		OP_READ = 1'b1
	} op_t;

	// One stored trace event.
	typedef struct packed {
		logic [DET_W-1:0]  detail;
		logic [SEV_W-1:0]  severity;
		logic [CODE_W-1:0] code;
		logic [SEQ_W-1:0]  seq_num;
		logic [TS_W-1:0]   timestamp;
	} entry_t;

	// Control sequencer states.
	typedef enum logic [1:0] {
		ST_IDLE = 2'b01,
		ST_READ = 2'b10
	} state_t;

endpackage

`default_nettype wire

### design/event_ring_log_overwrite_oldest.sv
`timescale 1ns / 1ps
`default_nettype none

// Event trace ring that keeps the last RING_DEPTH events and overwrites the
// oldest when full. A push (tuser 0) stores the event with the next sequence
// number, which runs from 1 and skips zero on wrap, and answers in the cycle
// after it is taken, so pushes stream at one word per cycle while m_tready is
// high. A read (tuser 1) fetches the entry at a logical index from the oldest
// event through the synchronous read port of the event memory, then the output
// register. Every result word carries the retained count, the saturating
// dropped total and the peak count. A result waiting at the master side holds
// off new words only until it is taken.

module event_ring_log_overwrite_oldest
	import erlo_pkg::*;
#(
	parameter int RING_DEPTH = RING_DEPTH_DEF
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  s_tvalid,
	output logic                       s_tready,
	// event_time, event_code, event_severity, event_detail, read_index
	input  wire logic [IN_DATA_W-1:0]  s_tdata,
	// operation
	input  wire logic                  s_tuser,
	output logic                       m_tvalid,
	input  wire logic                  m_tready,
	// out_event_time, out_sequence, out_code, out_severity, out_detail,
	// stored_count, dropped_total, peak_count
	output logic [OUT_DATA_W-1:0]      m_tdata,
	// ok, overwrote
	output logic [1:0]                 m_tuser
);

	localparam int AW    = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
	localparam int CNT_W = $clog2(RING_DEPTH + 1);
	localparam int SUM_W = ((CNT_W > IDX_W) ? CNT_W : IDX_W) + 1;
	localparam int PAD_W = OUT_DATA_W - (TS_W + SEQ_W + CODE_W + SEV_W + DET_W
		+ 2 * CNT_O_W + DROP_W);

	localparam logic [SUM_W-1:0] DEPTH_S = SUM_W'(RING_DEPTH);
	localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(RING_DEPTH);
	localparam logic [AW-1:0]    LAST_SLOT = AW'(RING_DEPTH - 1);

	// Input word fields.
	logic [TS_W-1:0]   in_ts;
	logic [CODE_W-1:0] in_code;
	logic [SEV_W-1:0]  in_sev;
	logic [DET_W-1:0]  in_det;
	logic [IDX_W-1:0]  in_idx;

	assign in_ts   = s_tdata[63:0];
	assign in_code = s_tdata[71:64];
	assign in_sev  = s_tdata[74:72];
	assign in_det  = s_tdata[106:75];
	assign in_idx  = s_tdata[112:107];

	// Control state.
	state_t            state_q;
	logic [AW-1:0]     oldest_q;
	logic [CNT_W-1:0]  held_q;
	logic [SEQ_W-1:0]  seq_q;
	logic [DROP_W-1:0] drop_q;
	logic [CNT_W-1:0]  peak_q;
	logic              rd_ok_q;

	// Output register.
	logic                  m_tvalid_q;
	logic [OUT_DATA_W-1:0] m_tdata_q;
	logic [1:0]            m_tuser_q;

	logic   out_free;
	logic   in_acc;
	logic   is_push;
	logic   full;
	entry_t wr_entry;
	entry_t rd_entry;

	logic [SUM_W-1:0]  push_sum;
	logic [SUM_W-1:0]  read_sum;
	logic [AW-1:0]     push_slot;
	logic [AW-1:0]     read_slot;
	logic              read_ok;
	logic [CNT_W-1:0]  held_n;
	logic [AW-1:0]     oldest_n;
	logic [DROP_W-1:0] drop_n;
	logic [CNT_W-1:0]  peak_n;
	logic [SEQ_W-1:0]  seq_n;

	// Handshake.
	assign out_free = !m_tvalid_q || m_tready;
	assign s_tready = (state_q == ST_IDLE) && out_free;
	assign in_acc   = s_tvalid && s_tready;
	assign is_push  = (op_t'(s_tuser) == OP_PUSH);

	// Slot arithmetic: the sums stay below twice the depth, so one
	// conditional subtract wraps them.
	assign full     = (held_q == DEPTH_C);
	assign push_sum = SUM_W'(oldest_q) + SUM_W'(held_q);
	assign read_sum = SUM_W'(oldest_q) + SUM_W'(in_idx);
	assign push_slot = full ? oldest_q
		: ((push_sum >= DEPTH_S) ? AW'(push_sum - DEPTH_S) : AW'(push_sum));
	assign read_slot = (read_sum >= DEPTH_S) ? AW'(read_sum - DEPTH_S) : AW'(read_sum);
	assign read_ok   = SUM_W'(in_idx) < SUM_W'(held_q);

	// Next values of the ring bookkeeping after a push.
	assign held_n   = full ? held_q : held_q + CNT_W'(1);
	assign oldest_n = !full ? oldest_q
		: ((oldest_q == LAST_SLOT) ? '0 : oldest_q + AW'(1));
	assign drop_n   = (full && !(&drop_q)) ? drop_q + DROP_W'(1) : drop_q;
	assign peak_n   = (peak_q < held_n) ? held_n : peak_q;
	assign seq_n    = (&seq_q) ? SEQ_FIRST : seq_q + SEQ_W'(1);

	// Entry written by a push.
	always_comb begin
		wr_entry.timestamp = in_ts;
		wr_entry.seq_num   = seq_q;
		wr_entry.code      = in_code;
		wr_entry.severity  = in_sev;
		wr_entry.detail    = in_det;
	end

	erlo_ram #(
		.DEPTH  (RING_DEPTH),
		.ADDR_W (AW)
	) u_ram (
		.clk   (clk),
		.we    (in_acc && is_push),
		.waddr (push_slot),
		.wdata (wr_entry),
		.re    (in_acc && !is_push),
		.raddr (read_slot),
		.rdata (rd_entry)
	);

	// Sequencer and ring bookkeeping.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			oldest_q <= '0;
			held_q   <= '0;
			seq_q    <= SEQ_FIRST;
			drop_q   <= '0;
			peak_q   <= '0;
			rd_ok_q  <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (in_acc) begin
						if (is_push) begin
							oldest_q <= oldest_n;
							held_q   <= held_n;
							seq_q    <= seq_n;
							drop_q   <= drop_n;
							peak_q   <= peak_n;
						end else begin
							rd_ok_q <= read_ok;
							state_q <= ST_READ;
						end
					end
				end
				ST_READ: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Output valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if ((in_acc && is_push) || (state_q == ST_READ && out_free)) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	// Output payload: a push answers at once, a read once the memory data returns.
	always_ff @(posedge clk) begin
		if (in_acc && is_push) begin
			m_tdata_q <= {PAD_W'(0), CNT_O_W'(peak_n), drop_n, CNT_O_W'(held_n),
				DET_W'(0), SEV_W'(0), CODE_W'(0), seq_q, TS_W'(0)};
			m_tuser_q <= {full, 1'b1};
		end else if (state_q == ST_READ && out_free) begin
			if (rd_ok_q) begin
				m_tdata_q <= {PAD_W'(0), CNT_O_W'(peak_q), drop_q, CNT_O_W'(held_q),
					rd_entry.detail, rd_entry.severity, rd_entry.code,
					rd_entry.seq_num, rd_entry.timestamp};
			end else begin
				m_tdata_q <= {PAD_W'(0), CNT_O_W'(peak_q), drop_q, CNT_O_W'(held_q),
					DET_W'(0), SEV_W'(0), CODE_W'(0), SEQ_W'(0), TS_W'(0)};
			end
			m_tuser_q <= {1'b0, rd_ok_q};
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign m_tuser  = m_tuser_q;

	// The ring never holds more than its depth.
	a_held_bound: assert property (@(posedge clk) disable iff (!arst_n)
		held_q <= DEPTH_C)
		else $error("retained count above ring depth");

	// The peak count never falls below the retained count.
	a_peak_ge_held: assert property (@(posedge clk) disable iff (!arst_n)
		peak_q >= held_q)
		else $error("peak count below retained count");

	// After a push the ring holds at least one event.
	a_push_fills: assert property (@(posedge clk) disable iff (!arst_n)
		(in_acc && is_push) |=> (held_q != '0))
		else $error("ring empty after a push");

	// The dropped total never decreases.
	a_drop_mono: assert property (@(posedge clk) disable iff (!arst_n)
		$past(arst_n) |-> (drop_q >= $past(drop_q)))
		else $error("dropped total decreased");

endmodule

`default_nettype wire

### design/erlo_ram.sv
`timescale 1ns / 1ps
`default_nettype none

module erlo_ram
	import erlo_pkg::*;
#(
	parameter int DEPTH  = RING_DEPTH_DEF,
	parameter int ADDR_W = 6
) (
	input  wire logic              clk,
	input  wire logic              we,
	input  wire logic [ADDR_W-1:0] waddr,
	input  wire entry_t            wdata,
	input  wire logic              re,
	input  wire logic [ADDR_W-1:0] raddr,
	output entry_t                 rdata
);

	entry_t mem [DEPTH];

	// Single write port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// Registered read port; the data holds until the next read.
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

`default_nettype wire

### tb/sv/tb_event_ring_log_overwrite_oldest.sv
`timescale 1ns / 1ps

module tb_event_ring_log_overwrite_oldest;
	import erlo_pkg::*;

	localparam int ITEM_COUNT     = 1100;
	localparam int WATCHDOG_LIMIT = 1000;
	localparam int DRAIN_CYCLES   = 8;
	localparam int IN_PAD_W  = IN_DATA_W - IDX_W - DET_W - SEV_W - CODE_W - TS_W;
	localparam int OUT_PAD_W = OUT_DATA_W - 2 * CNT_O_W - DROP_W - DET_W - SEV_W - CODE_W
		- SEQ_W - TS_W;

	// Slave-side word, lowest field last.
	typedef struct packed {
		logic [IN_PAD_W-1:0] pad;
		logic [IDX_W-1:0]    idx;
		logic [DET_W-1:0]    det;
		logic [SEV_W-1:0]    sev;
		logic [CODE_W-1:0]   code;
		logic [TS_W-1:0]     ts;
	} in_word_t;

	// Master-side word, lowest field last.
	typedef struct packed {
		logic [OUT_PAD_W-1:0] pad;
		logic [CNT_O_W-1:0]   peak;
		logic [DROP_W-1:0]    dropped;
		logic [CNT_O_W-1:0]   count;
		logic [DET_W-1:0]     det;
		logic [SEV_W-1:0]     sev;
		logic [CODE_W-1:0]    code;
		logic [SEQ_W-1:0]     seq;
		logic [TS_W-1:0]      ts;
	} out_word_t;

	// One answer of the ring: tuser bits above the data word.
	typedef struct packed {
		logic      overwrote;
		logic      ok;
		out_word_t word;
	} ring_result_t;

	typedef struct {
		op_t          op;
		in_word_t     word;
		bit           typed;
		ring_result_t want;
	} stim_row_t;

	typedef enum {MIX_FILL, MIX_PROBE, MIX_EVEN} mix_t;
	typedef enum {STALL_NONE, STALL_COIN, STALL_THREE_OF_FOUR, STALL_ONE_OF_THREE} stall_t;

	logic                  clk      = 1'b0;
	logic                  arst_n   = 1'b0;
	logic                  s_tvalid = 1'b0;
	logic                  s_tready;
	logic [IN_DATA_W-1:0]  s_tdata  = '0;
	logic                  s_tuser  = 1'b0;
	logic                  m_tvalid;
	logic                  m_tready = 1'b0;
	logic [OUT_DATA_W-1:0] m_tdata;
	logic [1:0]            m_tuser;

	// Own copy of the ring contents and pointers.
	logic [TS_W-1:0]   ring_ts   [RING_DEPTH_DEF];
	logic [SEQ_W-1:0]  ring_seq  [RING_DEPTH_DEF];
	logic [CODE_W-1:0] ring_code [RING_DEPTH_DEF];
	logic [SEV_W-1:0]  ring_sev  [RING_DEPTH_DEF];
	logic [DET_W-1:0]  ring_det  [RING_DEPTH_DEF];
	int                oldest_slot = 0;
	int                held_count  = 0;
	int                peak_held   = 0;
	logic [SEQ_W-1:0]  next_seq    = SEQ_FIRST;
	logic [DROP_W-1:0] drop_total  = '0;

	ring_result_t ring_answers_due[$];

	int fail_count     = 0;
	int words_checked  = 0;
	int push_count     = 0;
	int read_count     = 0;
	int miss_count     = 0;
	int overwrite_count = 0;
	int burst_left     = 0;
	int idle_cycles    = 0;
	int stall_tick     = 0;
	stall_t stall_mode = STALL_NONE;

	event_ring_log_overwrite_oldest i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	always #1 clk = ~clk;

	// Works out the ring's answer to one word and moves the ring state on.
	function automatic ring_result_t ring_answer(op_t op, in_word_t w);
		ring_result_t r;
		int slot;
		r = '0;
		if (op == OP_PUSH) begin
			if (held_count < RING_DEPTH_DEF) begin
				slot = (oldest_slot + held_count) % RING_DEPTH_DEF;
				held_count++;
			end else begin
				slot = oldest_slot;
				oldest_slot = (oldest_slot + 1) % RING_DEPTH_DEF;
				if (drop_total != '1)
					drop_total++;
				r.overwrote = 1'b1;
			end
			ring_ts[slot]   = w.ts;
			ring_seq[slot]  = next_seq;
			ring_code[slot] = w.code;
			ring_sev[slot]  = w.sev;
			ring_det[slot]  = w.det;
			r.word.seq = next_seq;
			next_seq++;
			// Zero is never handed out as a sequence number.
			if (next_seq == '0)
				next_seq = SEQ_FIRST;
			if (peak_held < held_count)
				peak_held = held_count;
			r.ok = 1'b1;
		end else if (int'(w.idx) < held_count) begin
			slot = (oldest_slot + int'(w.idx)) % RING_DEPTH_DEF;
			r.word.ts   = ring_ts[slot];
			r.word.seq  = ring_seq[slot];
			r.word.code = ring_code[slot];
			r.word.sev  = ring_sev[slot];
			r.word.det  = ring_det[slot];
			r.ok = 1'b1;
		end
		r.word.count   = CNT_O_W'(held_count);
		r.word.dropped = drop_total;
		r.word.peak    = CNT_O_W'(peak_held);
		return r;
	endfunction

	function automatic in_word_t make_word(logic [TS_W-1:0] ts, logic [CODE_W-1:0] code,
			logic [SEV_W-1:0] sev, logic [DET_W-1:0] det, logic [IDX_W-1:0] idx);
		in_word_t w;
		w = '0;
		w.ts   = ts;
		w.code = code;
		w.sev  = sev;
		w.det  = det;
		w.idx  = idx;
		return w;
	endfunction

	function automatic ring_result_t make_result(logic ok, logic ovw, logic [TS_W-1:0] ts,
			logic [SEQ_W-1:0] seq, logic [CODE_W-1:0] code, logic [SEV_W-1:0] sev,
			logic [DET_W-1:0] det, logic [CNT_O_W-1:0] count, logic [DROP_W-1:0] dropped,
			logic [CNT_O_W-1:0] peak);
		ring_result_t r;
		r = '0;
		r.ok           = ok;
		r.overwrote    = ovw;
		r.word.ts      = ts;
		r.word.seq     = seq;
		r.word.code    = code;
		r.word.sev     = sev;
		r.word.det     = det;
		r.word.count   = count;
		r.word.dropped = dropped;
		r.word.peak    = peak;
		return r;
	endfunction

	function automatic stim_row_t make_row(op_t op, in_word_t w, bit typed, ring_result_t want);
		stim_row_t row;
		row.op    = op;
		row.word  = w;
		row.typed = typed;
		row.want  = want;
		return row;
	endfunction

	task automatic check_field(string name, logic [63:0] want, logic [63:0] got);
		if (want !== got) begin
			$error("%s: expected 0x%0h, got 0x%0h", name, want, got);
			fail_count++;
		end
	endtask

	// Offers one word, waits for it to be taken, books its answer, then
	// perhaps leaves a gap before the next word.
	task automatic send_word(op_t op, in_word_t w, bit typed, ring_result_t want);
		ring_result_t predicted;
		s_tvalid <= 1'b1;
		s_tuser  <= op;
		s_tdata  <= w;
		do @(posedge clk); while (!s_tready);
		predicted = ring_answer(op, w);
		ring_answers_due.push_back(typed ? want : predicted);
		if (op == OP_PUSH)
			push_count++;
		else
			read_count++;
		if (!predicted.ok)
			miss_count++;
		if (predicted.overwrote)
			overwrite_count++;
		if (burst_left > 0) begin
			burst_left--;
		end else begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
			burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60)
				: $urandom_range(0, 8);
		end
	endtask

	// The receiver switches between randomly chosen stall patterns.
	always @(posedge clk) begin
		if (stall_tick % 50 == 0)
			stall_mode = stall_t'($urandom_range(0, 3));
		case (stall_mode)
			STALL_NONE:          m_tready <= 1'b1;
			STALL_COIN:          m_tready <= 1'($urandom_range(0, 1));
			STALL_THREE_OF_FOUR: m_tready <= (stall_tick % 4 != 3);
			default:             m_tready <= (stall_tick % 3 == 0);
		endcase
		stall_tick++;
	end

	// Compares every result word with the oldest answer due, and watches
	// for a stalled run.
	always @(posedge clk) begin : result_check
		ring_result_t got;
		ring_result_t want;
		if (arst_n) begin
			if (m_tvalid && m_tready) begin
				got = {m_tuser, m_tdata};
				if (ring_answers_due.size() == 0) begin
					$error("result word arrived with no answer due");
					fail_count++;
				end else begin
					want = ring_answers_due.pop_front();
					check_field("ok", 64'(want.ok), 64'(got.ok));
					check_field("overwrote", 64'(want.overwrote), 64'(got.overwrote));
					check_field("out_event_time", want.word.ts, got.word.ts);
					check_field("out_sequence", 64'(want.word.seq), 64'(got.word.seq));
					check_field("out_code", 64'(want.word.code), 64'(got.word.code));
					check_field("out_severity", 64'(want.word.sev), 64'(got.word.sev));
					check_field("out_detail", 64'(want.word.det), 64'(got.word.det));
					check_field("stored_count", 64'(want.word.count),
						64'(got.word.count));
					check_field("dropped_total", 64'(want.word.dropped),
						64'(got.word.dropped));
					check_field("peak_count", 64'(want.word.peak), 64'(got.word.peak));
				end
				words_checked++;
			end
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles >= WATCHDOG_LIMIT) begin
				$display("Timed out with %0d answers still due.", ring_answers_due.size());
				$display("== FAIL ==");
				$finish;
			end
		end
	end

	initial begin : stimulus
		stim_row_t rows[$];
		ring_result_t empty_miss;
		ring_result_t pair_miss;
		in_word_t w;
		op_t op;
		mix_t mix;
		int mix_left;

		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed table: empty ring, extremes, reads at and past the count.
		empty_miss = make_result(1'b0, 1'b0, '0, '0, '0, '0, '0, '0, '0, '0);
		pair_miss  = make_result(1'b0, 1'b0, '0, '0, '0, '0, '0, 7'd2, '0, 7'd2);
		rows.push_back(make_row(OP_READ,
			make_word(64'h0123_4567_89AB_CDEF, 8'h5A, 3'd3, 32'hDEAD_BEEF, 6'd0),
			1'b1, empty_miss));
		rows.push_back(make_row(OP_READ, make_word('0, '0, '0, '0, 6'd63), 1'b1, empty_miss));
		rows.push_back(make_row(OP_PUSH, make_word('1, 8'hFF, 3'd7, '1, 6'd63), 1'b1,
			make_result(1'b1, 1'b0, '0, 32'd1, '0, '0, '0, 7'd1, '0, 7'd1)));
		rows.push_back(make_row(OP_PUSH, make_word('0, '0, '0, '0, '0), 1'b1,
			make_result(1'b1, 1'b0, '0, 32'd2, '0, '0, '0, 7'd2, '0, 7'd2)));
		rows.push_back(make_row(OP_READ, make_word('0, '0, '0, '0, 6'd0), 1'b1,
			make_result(1'b1, 1'b0, '1, 32'd1, 8'hFF, 3'd7, '1, 7'd2, '0, 7'd2)));
		rows.push_back(make_row(OP_READ, make_word('1, 8'hFF, 3'd7, '1, 6'd1), 1'b1,
			make_result(1'b1, 1'b0, '0, 32'd2, '0, '0, '0, 7'd2, '0, 7'd2)));
		rows.push_back(make_row(OP_READ, make_word('0, '0, '0, '0, 6'd2), 1'b1, pair_miss));
		rows.push_back(make_row(OP_READ, make_word('0, '0, '0, '0, 6'd63), 1'b1, pair_miss));
		rows.push_back(make_row(OP_PUSH,
			make_word(64'hAAAA_AAAA_AAAA_AAAA, 8'h55, 3'd2, 32'h5555_5555, 6'h2A),
			1'b0, '0));
		rows.push_back(make_row(OP_PUSH,
			make_word(64'h5555_5555_5555_5555, 8'hAA, 3'd5, 32'hAAAA_AAAA, 6'h15),
			1'b0, '0));
		rows.push_back(make_row(OP_PUSH,
			make_word(64'h8000_0000_0000_0001, 8'h01, 3'd1, 32'h8000_0001, '0),
			1'b0, '0));
		rows.push_back(make_row(OP_PUSH,
			make_word(64'h7FFF_FFFF_FFFF_FFFE, 8'h80, 3'd6, 32'h7FFF_FFFE, '0),
			1'b0, '0));
		rows.push_back(make_row(OP_READ, make_word('0, '0, '0, '0, 6'd2), 1'b0, '0));
		rows.push_back(make_row(OP_READ, make_word('0, '0, '0, '0, 6'd3), 1'b0, '0));
		rows.push_back(make_row(OP_READ, make_word('0, '0, '0, '0, 6'd5), 1'b0, '0));
		rows.push_back(make_row(OP_READ, make_word('0, '0, '0, '0, 6'd6), 1'b0, '0));
		foreach (rows[i])
			send_word(rows[i].op, rows[i].word, rows[i].typed, rows[i].want);

		// Random part in stretches that fill, probe or mix evenly.
		mix = MIX_EVEN;
		mix_left = 0;
		for (int n = 0; n < ITEM_COUNT; n++) begin
			if (mix_left == 0) begin
				mix = mix_t'($urandom_range(0, 2));
				mix_left = $urandom_range(10, 80);
			end
			mix_left--;
			case (mix)
				MIX_FILL:  op = ($urandom_range(0, 9) < 9) ? OP_PUSH : OP_READ;
				MIX_PROBE: op = ($urandom_range(0, 9) < 2) ? OP_PUSH : OP_READ;
				default:   op = ($urandom_range(0, 1) == 0) ? OP_PUSH : OP_READ;
			endcase
			w = '0;
			w.ts   = {$urandom(), $urandom()};
			if ($urandom_range(0, 15) == 0)
				w.ts = ($urandom_range(0, 1) == 0) ? '1 : '0;
			w.code = CODE_W'($urandom());
			w.sev  = SEV_W'($urandom());
			w.det  = $urandom();
			// Mostly indices up to the count, so that reads land in range.
			if (held_count == 0 || $urandom_range(0, 3) == 0)
				w.idx = IDX_W'($urandom());
			else
				w.idx = IDX_W'($urandom_range(0, (held_count > 63) ? 63 : held_count));
			send_word(op, w, 1'b0, '0);
		end
		s_tvalid <= 1'b0;

		while (ring_answers_due.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("Checked %0d result words: %0d pushes, %0d reads, %0d of them out of range.",
			words_checked, push_count, read_count, miss_count);
		$display("Ring filled to %0d entries; %0d pushes overwrote the oldest event.",
			peak_held, overwrite_count);
		if (fail_count == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule

### event_ring_log_overwrite_oldest.f
design/erlo_pkg.sv
design/erlo_ram.sv
design/event_ring_log_overwrite_oldest.sv
tb/sv/tb_event_ring_log_overwrite_oldest.sv
